// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Each macro samples on clk and is
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mcal_pkg
// Types and constants shared by the magnetometer calibration and heading
// pipeline.
// ---------------------------------------------------------------------------
package mcal_pkg;

  // Width of the CORDIC x and y datapath and of the angle accumulator.
  localparam int unsigned CW = 27;
  localparam int unsigned ZW = 25;

  // Angle constants in 1/16384 degree.
  localparam logic signed [ZW-1:0] HALF_TURN = 25'sd2949120;
  localparam int unsigned ATAN_LEN = 24;
  localparam logic signed [ZW-1:0] ATAN_FINE [ATAN_LEN] = '{
    25'sd737280, 25'sd435242, 25'sd229970, 25'sd116736,
    25'sd58595,  25'sd29326,  25'sd14667,  25'sd7334,
    25'sd3667,   25'sd1833,   25'sd917,    25'sd458,
    25'sd229,    25'sd115,    25'sd57,     25'sd29,
    25'sd14,     25'sd7,      25'sd4,      25'sd2,
    25'sd1,      25'sd0,      25'sd0,      25'sd0
  };

  // Heading limit in 1/64 degree.
  localparam logic signed [16:0] HEAD_MAX = 17'sd11520;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CAL_ENABLE = 3'd0,
    REG_BIAS_X     = 3'd1,
    REG_BIAS_Y     = 3'd2,
    REG_BIAS_Z     = 3'd3,
    REG_ROW0       = 3'd4,
    REG_ROW1       = 3'd5,
    REG_ROW2       = 3'd6,
    REG_NONE       = 3'd7
  } reg_idx_t;

  // Calibration settings seen by the correction stages.
  typedef struct packed {
    logic               en;
    logic signed [15:0] bias_x;
    logic signed [15:0] bias_y;
    logic signed [15:0] bias_z;
    logic        [47:0] row0;
    logic        [47:0] row1;
    logic        [47:0] row2;
  } cal_cfg_t;

  // One field vector with its valid flag.
  typedef struct packed {
    logic               vld;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

  // Contents of one CORDIC cell.
  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   cx;
    logic signed [15:0]   cy;
    logic signed [15:0]   cz;
  } cordic_t;

endpackage
`default_nettype wire

// ===== rtl/mcal_correct.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mcal_correct
// Three-stage hard-iron subtract, matrix multiply, round and saturate.
// ---------------------------------------------------------------------------
module mcal_correct (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mcal_pkg::cal_cfg_t cfg,
  input  wire mcal_pkg::vec_t   raw,
  output mcal_pkg::vec_t        cal
);

  // Stage 1: bias difference.
  logic               v1_r;
  logic signed [16:0] d_r [3];
  logic signed [15:0] raw1_r [3];

  // Stage 2: products, coefficient index [row][column].
  logic               v2_r;
  logic signed [32:0] p_r [3][3];
  logic signed [15:0] raw2_r [3];

  // Stage 3: rounded rows.
  mcal_pkg::vec_t     cal_r;
  mcal_pkg::vec_t     cal_nxt;

  logic        [47:0] rows [3];
  logic signed [15:0] coef [3][3];
  logic signed [35:0] sum  [3];
  logic signed [15:0] sat  [3];

  always_comb begin
    rows[0] = cfg.row0;
    rows[1] = cfg.row1;
    rows[2] = cfg.row2;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = $signed(rows[r][16*c +: 16]);
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r[0] <= 17'(raw.x) - 17'(cfg.bias_x);
    d_r[1] <= 17'(raw.y) - 17'(cfg.bias_y);
    d_r[2] <= 17'(raw.z) - 17'(cfg.bias_z);
    raw1_r[0] <= raw.x;
    raw1_r[1] <= raw.y;
    raw1_r[2] <= raw.z;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_r[r][c] <= coef[r][c] * d_r[c];
      end
    end
    raw2_r <= raw1_r;
    cal_r  <= cal_nxt;
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      cal_r.vld <= 1'b0;
    end else begin
      v1_r <= raw.vld;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 36'(p_r[r][0]) + 36'(p_r[r][1]) + 36'(p_r[r][2]) + 36'sd8192;
      if (sum[r] >= 36'sd536870912) begin
        sat[r] = 16'sd32767;
      end else if (sum[r] < -36'sd536870912) begin
        sat[r] = -16'sd32768;
      end else begin
        sat[r] = 16'(sum[r] >>> 14);
      end
    end
    cal_nxt.vld = v2_r;
    cal_nxt.x   = cfg.en ? sat[0] : raw2_r[0];
    cal_nxt.y   = cfg.en ? sat[1] : raw2_r[1];
    cal_nxt.z   = cfg.en ? sat[2] : raw2_r[2];
  end

  assign cal = cal_r;

endmodule
`default_nettype wire

// ===== rtl/mcal_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mcal_cordic_cell
// One vectoring CORDIC iteration with a fixed shift, registered.
// ---------------------------------------------------------------------------
module mcal_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mcal_pkg::cordic_t in_c,
  output mcal_pkg::cordic_t      out_c
);

  localparam logic signed [mcal_pkg::ZW-1:0] ANG = mcal_pkg::ATAN_FINE[IDX];

  mcal_pkg::cordic_t cell_r;
  mcal_pkg::cordic_t cell_nxt;

  logic signed [mcal_pkg::CW-1:0] xs;
  logic signed [mcal_pkg::CW-1:0] ys;

  always_comb begin
    xs       = in_c.x >>> IDX;
    ys       = in_c.y >>> IDX;
    cell_nxt = in_c;
    if (!in_c.y[mcal_pkg::CW-1]) begin
      cell_nxt.x = in_c.x + ys;
      cell_nxt.y = in_c.y - xs;
      cell_nxt.z = in_c.z + ANG;
    end else begin
      cell_nxt.x = in_c.x - ys;
      cell_nxt.y = in_c.y + xs;
      cell_nxt.z = in_c.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end
  end

  assign out_c = cell_r;

endmodule
`default_nettype wire

// ===== rtl/magnetometer_calibrate_heading.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// magnetometer_calibrate_heading
// Hard/soft-iron correction of a three-axis field sample and its heading.
// ---------------------------------------------------------------------------
// The block takes one sample in every clock cycle: busy is never raised, so
// an item is accepted whenever start is high. Each item yields exactly one
// result, shown for a single cycle with out_valid high; the receiver cannot
// stall the block, so it must take every result in the cycle in which it
// appears. An item passes through a capture register, three correction
// stages (bias subtract, matrix multiply, round and saturate), a
// pre-rotation stage, the CORDIC chain with one registered cell per
// iteration and the output register. Configuration writes are always taken
// (cfg_ready is high) and must only be made while no item is in flight.
module magnetometer_calibrate_heading #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Sample input.
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_mag_x,
  input  wire logic signed [15:0] in_mag_y,
  input  wire logic signed [15:0] in_mag_z,
  // Result output.
  output logic                    out_valid,
  output logic signed [15:0]      out_cal_x,
  output logic signed [15:0]      out_cal_y,
  output logic signed [15:0]      out_cal_z,
  output logic signed [14:0]      out_heading,
  // Register write port.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data
);

  localparam int unsigned CW = mcal_pkg::CW;
  localparam int unsigned ZW = mcal_pkg::ZW;
  localparam int unsigned LATENCY = CORDIC_STEPS + 6;

  // Configuration registers.
  mcal_pkg::cal_cfg_t cfg_r;

  // Pipeline signals.
  mcal_pkg::vec_t    in_r;
  mcal_pkg::vec_t    cal;
  mcal_pkg::cordic_t chain [CORDIC_STEPS+1];
  mcal_pkg::cordic_t pre_nxt;

  logic               out_valid_r;
  logic signed [15:0] out_cal_x_r;
  logic signed [15:0] out_cal_y_r;
  logic signed [15:0] out_cal_z_r;
  logic signed [14:0] out_heading_r;
  logic signed [14:0] out_heading_nxt;

  logic signed [16:0] xe;
  logic signed [16:0] ye;
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zh;
  logic signed [16:0] hd;

  logic accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Register writes. Index seven is not a register and is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.en     <= 1'b0;
      cfg_r.bias_x <= 16'sd155;
      cfg_r.bias_y <= 16'sd35;
      cfg_r.bias_z <= 16'sd56;
      cfg_r.row0   <= 48'd16384;
      cfg_r.row1   <= 48'd16384 << 16;
      cfg_r.row2   <= 48'd16384 << 32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mcal_pkg::reg_idx_t'(cfg_index))
        mcal_pkg::REG_CAL_ENABLE: cfg_r.en     <= cfg_data[0];
        mcal_pkg::REG_BIAS_X:     cfg_r.bias_x <= $signed(cfg_data[15:0]);
        mcal_pkg::REG_BIAS_Y:     cfg_r.bias_y <= $signed(cfg_data[15:0]);
        mcal_pkg::REG_BIAS_Z:     cfg_r.bias_z <= $signed(cfg_data[15:0]);
        mcal_pkg::REG_ROW0:       cfg_r.row0   <= cfg_data;
        mcal_pkg::REG_ROW1:       cfg_r.row1   <= cfg_data;
        mcal_pkg::REG_ROW2:       cfg_r.row2   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the sample every cycle; the valid flag marks an accepted one.
  always_ff @(posedge clk) begin
    in_r.x <= in_mag_x;
    in_r.y <= in_mag_y;
    in_r.z <= in_mag_z;
    if (!rst_n) begin
      in_r.vld <= 1'b0;
    end else begin
      in_r.vld <= accept;
    end
  end

  mcal_correct u_correct (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .raw   (in_r),
    .cal   (cal)
  );

  // Pre-rotation: a vector in the left half plane is turned through half a
  // turn so that the iterations only have to cover plus or minus ninety
  // degrees, and x and y gain eight fraction bits.
  always_comb begin
    xe = 17'(cal.x);
    ye = 17'(cal.y);
    zr = '0;
    if (cal.x < 0) begin
      zr = cal.y[15] ? -mcal_pkg::HALF_TURN : mcal_pkg::HALF_TURN;
      xe = -xe;
      ye = -ye;
    end
    pre_nxt.vld  = cal.vld;
    pre_nxt.zero = (cal.x == 16'sd0) && (cal.y == 16'sd0);
    pre_nxt.x    = CW'(xe) <<< 8;
    pre_nxt.y    = CW'(ye) <<< 8;
    pre_nxt.z    = zr;
    pre_nxt.cx   = cal.x;
    pre_nxt.cy   = cal.y;
    pre_nxt.cz   = cal.z;
  end

  always_ff @(posedge clk) begin
    chain[0] <= pre_nxt;
    if (!rst_n) begin
      chain[0].vld <= 1'b0;
    end
  end

  // One cell per iteration; each hands its vector to the next every cycle.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    mcal_cordic_cell #(
      .IDX (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .in_c  (chain[k]),
      .out_c (chain[k+1])
    );
  end

  // Round the angle to 1/64 degree and keep it inside half a turn.
  always_comb begin
    zh = chain[CORDIC_STEPS].z + ZW'(128);
    hd = 17'(zh >>> 8);
    if (chain[CORDIC_STEPS].zero) begin
      out_heading_nxt = '0;
    end else if (hd > mcal_pkg::HEAD_MAX) begin
      out_heading_nxt = 15'(mcal_pkg::HEAD_MAX);
    end else if (hd < -mcal_pkg::HEAD_MAX) begin
      out_heading_nxt = 15'(-mcal_pkg::HEAD_MAX);
    end else begin
      out_heading_nxt = 15'(hd);
    end
  end

  always_ff @(posedge clk) begin
    out_cal_x_r   <= chain[CORDIC_STEPS].cx;
    out_cal_y_r   <= chain[CORDIC_STEPS].cy;
    out_cal_z_r   <= chain[CORDIC_STEPS].cz;
    out_heading_r <= out_heading_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[CORDIC_STEPS].vld;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cal_x   = out_cal_x_r;
  assign out_cal_y   = out_cal_y_r;
  assign out_cal_z   = out_cal_z_r;
  assign out_heading = out_heading_r;

  // Checks.
`include "assert_macros.svh"

  `ASSERT_SAME(a_result_has_item, out_valid, $past(accept, LATENCY),
               "result without an item")
  `ASSERT_SAME(a_heading_range, out_valid,
               (out_heading <= 15'sd11520) && (out_heading >= -15'sd11520),
               "heading out of range")
  `ASSERT_SAME(a_zero_heading,
               out_valid && (out_cal_x == 16'sd0) && (out_cal_y == 16'sd0),
               out_heading == 15'sd0, "zero vector heading")

endmodule
`default_nettype wire
